// ===== design/bba_pkg.sv =====
// Package with the types and constants of the bucket bump allocator.
`timescale 1ns / 1ps
package bba_pkg;
    localparam int MaxBuckets   = 16;
    localparam int IdxW         = $clog2(MaxBuckets);
    localparam int CntW         = $clog2(MaxBuckets + 1);
    localparam int AddrW        = 24;
    localparam int NumW         = 20;
    localparam int FreedW       = 21;
    localparam int TopW         = 25;
    localparam logic [TopW-1:0] RegionObjects = 25'd16777216;
    localparam logic [15:0]     ThresholdReset = 16'd1024;

    localparam logic CmdAlloc = 1'b0;
    localparam logic CmdFree  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_NO_MATCH  = 2'd3
    } status_t;

    typedef struct packed {
        logic                 cmd;
        logic [NumW-1:0]      count;
        logic [AddrW-1:0]     free_address;
    } in_item_t;

    typedef struct packed {
        logic [AddrW-1:0]     granted_address;
        logic [1:0]           status;
        logic                 bucket_released;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_OPEN,
        S_SHIFT,
        S_DONE
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;       // capture the request
        logic clr_idx;    // scan index to zero
        logic inc_idx;    // next entry
        logic rd;         // read entry at index
        logic hit_upd;    // update the matched entry
        logic open;       // append a new bucket
        logic shift;      // copy entry idx+1 into idx
        logic shrink;     // drop the last bucket
        logic set_res;    // latch result
        status_t res_st;
        logic res_rel;
        logic res_addr;   // result carries the scan address
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_free;
        logic big;        // allocate above threshold
        logic at_end;     // index reached bucket count
        logic hit;        // current entry fits / matches
        logic release_ok; // free empties the entry
        logic full;
        logic exhausted;
        logic shift_end;  // idx+1 reached bucket count
    } stat_t;
endpackage

// ===== design/bba_datapath.sv =====
// Datapath of the bucket bump allocator: bucket table, region pointer and scan logic.
`timescale 1ns / 1ps
module bba_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_data,
    input  bba_pkg::in_item_t req,
    input  bba_pkg::cmd_t    cmd_c,
    output bba_pkg::stat_t   stat,
    output bba_pkg::out_item_t result
);
    import bba_pkg::*;

    logic [AddrW-1:0]  base_mem  [MaxBuckets];
    logic [NumW-1:0]   cap_mem   [MaxBuckets];
    logic [NumW-1:0]   used_mem  [MaxBuckets];
    logic [FreedW-1:0] freed_mem [MaxBuckets];

    logic [15:0]       threshold_reg;
    logic [CntW-1:0]   count_reg;
    logic [TopW-1:0]   top_reg;
    logic [CntW-1:0]   idx_reg;
    in_item_t          req_reg;
    out_item_t         result_reg;

    logic [AddrW-1:0]  base_rd_reg;
    logic [NumW-1:0]   cap_rd_reg;
    logic [NumW-1:0]   used_rd_reg;
    logic [FreedW-1:0] freed_rd_reg;

    logic [IdxW-1:0]   idx;
    logic [IdxW-1:0]   idx_p1;
    logic [CntW-1:0]   idx_p1_w;
    logic [NumW-1:0]   open_cap;
    logic [NumW-1:0]   open_used;
    logic [TopW:0]     open_sum;
    logic [NumW:0]     room;
    logic [TopW-1:0]   hi;
    logic [TopW-1:0]   req_end;
    logic [FreedW-1:0] freed_new;
    logic              big;

    assign idx      = idx_reg[IdxW-1:0];
    assign idx_p1_w = idx_reg + CntW'(1);
    assign idx_p1   = idx_p1_w[IdxW-1:0];
    assign big      = {12'd0, req_reg.count} > {16'd0, threshold_reg};
    assign open_cap  = big ? req_reg.count : {4'd0, threshold_reg};
    assign open_used = req_reg.count;
    assign open_sum  = {1'b0, top_reg} + (TopW + 1)'(open_cap);
    assign room      = {1'b0, cap_rd_reg} - {1'b0, used_rd_reg};
    assign hi        = {1'b0, base_rd_reg} + TopW'(cap_rd_reg);
    assign req_end   = {1'b0, req_reg.free_address} + TopW'(req_reg.count);
    assign freed_new = freed_rd_reg + FreedW'(req_reg.count);

    always_comb
    begin
        stat.is_free   = req_reg.cmd == CmdFree;
        stat.big       = big;
        stat.at_end    = idx_reg >= count_reg;
        stat.shift_end = idx_p1_w >= count_reg;
        stat.full      = count_reg >= CntW'(MaxBuckets);
        stat.exhausted = open_sum > (TopW + 1)'(RegionObjects);
        if (req_reg.cmd == CmdFree)
            stat.hit = (base_rd_reg <= req_reg.free_address) && (req_end <= hi);
        else
            stat.hit = !room[NumW] && (room[NumW-1:0] >= req_reg.count);
        stat.release_ok = ({1'b0, freed_new} >= (FreedW + 1)'(cap_rd_reg))
                       || ({1'b0, freed_new} >= (FreedW + 1)'(used_rd_reg));
    end

    // Table storage, request capture and result register.
    always_ff @(posedge clk)
    begin
        if (cmd_c.rd)
        begin
            base_rd_reg  <= base_mem[idx];
            cap_rd_reg   <= cap_mem[idx];
            used_rd_reg  <= used_mem[idx];
            freed_rd_reg <= freed_mem[idx];
        end
        if (cmd_c.hit_upd)
        begin
            if (req_reg.cmd == CmdFree)
                freed_mem[idx] <= freed_new;
            else
                used_mem[idx] <= used_rd_reg + req_reg.count;
        end
        else if (cmd_c.open)
        begin
            base_mem[count_reg[IdxW-1:0]]  <= top_reg[AddrW-1:0];
            cap_mem[count_reg[IdxW-1:0]]   <= open_cap;
            used_mem[count_reg[IdxW-1:0]]  <= open_used;
            freed_mem[count_reg[IdxW-1:0]] <= '0;
        end
        else if (cmd_c.shift)
        begin
            base_mem[idx]  <= base_mem[idx_p1];
            cap_mem[idx]   <= cap_mem[idx_p1];
            used_mem[idx]  <= used_mem[idx_p1];
            freed_mem[idx] <= freed_mem[idx_p1];
        end
        if (cmd_c.load)
            req_reg <= req;
        if (cmd_c.set_res)
        begin
            result_reg.granted_address <= cmd_c.res_addr ?
                base_rd_reg + AddrW'(used_rd_reg) :
                (cmd_c.open ? top_reg[AddrW-1:0] : '0);
            result_reg.status          <= cmd_c.res_st;
            result_reg.bucket_released <= cmd_c.res_rel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= ThresholdReset;
            count_reg     <= '0;
            top_reg       <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                threshold_reg <= cfg_data;
            if (cmd_c.clr_idx)
                idx_reg <= '0;
            else if (cmd_c.inc_idx)
                idx_reg <= idx_p1_w;
            if (cmd_c.open)
            begin
                count_reg <= count_reg + CntW'(1);
                top_reg   <= open_sum[TopW-1:0];
            end
            else if (cmd_c.shrink)
            begin
                count_reg <= count_reg - CntW'(1);
                if (count_reg == CntW'(1))
                    top_reg <= '0;
            end
        end
    end

    assign result = result_reg;
endmodule

// ===== design/bba_ctrl.sv =====
// Controller state machine of the bucket bump allocator.
`timescale 1ns / 1ps
module bba_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  bba_pkg::stat_t stat,
    output bba_pkg::cmd_t  cmd_c
);
    import bba_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_c      = '0;
        cmd_c.res_st = ST_OK;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_c.load    = 1'b1;
                    cmd_c.clr_idx = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_READ:
            begin
                if (!stat.is_free && stat.big)
                    state_next = S_OPEN;
                else if (stat.at_end)
                begin
                    if (stat.is_free)
                    begin
                        cmd_c.set_res = 1'b1;
                        cmd_c.res_st  = ST_NO_MATCH;
                        state_next    = S_DONE;
                    end
                    else
                        state_next = S_OPEN;
                end
                else
                begin
                    cmd_c.rd   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.hit)
                begin
                    cmd_c.hit_upd = 1'b1;
                    cmd_c.set_res = 1'b1;
                    if (!stat.is_free)
                    begin
                        cmd_c.res_addr = 1'b1;
                        state_next     = S_DONE;
                    end
                    else if (stat.release_ok)
                    begin
                        cmd_c.res_rel = 1'b1;
                        state_next    = S_SHIFT;
                    end
                    else
                        state_next = S_DONE;
                end
                else
                begin
                    cmd_c.inc_idx = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_OPEN:
            begin
                cmd_c.set_res = 1'b1;
                if (stat.full)
                    cmd_c.res_st = ST_FULL;
                else if (stat.exhausted)
                    cmd_c.res_st = ST_EXHAUSTED;
                else
                    cmd_c.open = 1'b1;
                state_next = S_DONE;
            end
            S_SHIFT:
            begin
                // Close the gap one entry a cycle, then drop the tail.
                if (stat.shift_end)
                begin
                    cmd_c.shrink = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd_c.shift   = 1'b1;
                    cmd_c.inc_idx = 1'b1;
                end
            end
            S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule

// ===== design/bucket_bump_allocator.sv =====
// Top level of the bucket bump allocator.
`timescale 1ns / 1ps
// One transaction at a time: an allocate or free scans the bucket table from the front,
// reading and then checking each entry, while an allocate above the threshold opens a new
// bucket without a scan; a free that removes a bucket then closes the gap by shifting each
// later entry down and drops the tail. The result is held until taken and threshold
// may be written when idle.
module bucket_bump_allocator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bba_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bba_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data
);
    import bba_pkg::*;

    cmd_t  cmd_c;
    stat_t stat;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd_c     (cmd_c)
    );

    bba_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (in_data),
        .cmd_c    (cmd_c),
        .stat     (stat),
        .result   (out_data)
    );
endmodule

// ===== design/bba_checker.sv =====
// Port-level checker for the bucket bump allocator, bound to the top level.
`timescale 1ns / 1ps
module bba_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input bba_pkg::out_item_t out_data
);
    import bba_pkg::*;

    // One transaction in flight: no new request while a result waits.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");

    a_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.granted_address == '0)
        else $error("address on error");

    a_rel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bucket_released |-> out_data.status == ST_OK
            && out_data.granted_address == '0) else $error("bad release");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("accepted twice");
endmodule

bind bucket_bump_allocator bba_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
